FILE: rtl/battery_gauge_smoother_core_defines.svh
// Assertion macros shared by the battery gauge checker.
// No dependencies; included by files that hold concurrent assertions.
`ifndef BATTERY_GAUGE_SMOOTHER_CORE_DEFINES_SVH
`define BATTERY_GAUGE_SMOOTHER_CORE_DEFINES_SVH

// same-cycle implication, held off while reset is low
`define BGS_ASSERT_IMPLY(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("bgs check failed");

// next-cycle implication, held off while reset is low
`define BGS_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("bgs check failed");

`endif

FILE: rtl/bgs_pkg.sv
// Shared types, widths and constants of the battery gauge smoother.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package bgs_pkg;

    localparam int SAMPLE_W     = 12;
    localparam int SUM_W        = 16;
    localparam int CNT_W        = 4;
    localparam int MV_W         = 14;
    localparam int GAIN_W       = 16;
    localparam int PCT_W        = 7;
    localparam int SEG_W        = 2;
    localparam int SPAN_W       = 5;
    localparam int PROD_W       = 45;
    localparam int SMOOTH_X_W   = 17;
    localparam int DIV_W        = 20;
    localparam int DVSR_W       = 14;
    localparam int DIV_STEPS    = DIV_W / 2;
    localparam int DIV_CNT_W    = 4;
    localparam int SCALE_SHIFT  = 12;
    localparam int RECIP5_SHIFT = 18;
    localparam int RECIP_SHIFT  = 24;
    localparam int RECIP_W      = 25;
    localparam int QUEUE_DEPTH  = 2;
    localparam int QPTR_W       = 1;
    localparam int APB_ADDR_W   = 5;
    localparam int APB_DATA_W   = 32;
    localparam int SAMPLES_DEF  = 10;

    localparam logic [MV_W-1:0]   MV_MAX  = 14'h3FFF;
    localparam logic [15:0]       RECIP5  = 16'd52429;  // ceil(2^18 / 5)
    localparam logic [PCT_W-1:0]  PCT_MAX = 7'd100;

    localparam logic [PCT_W-1:0]  BASE_GOOD = 7'd75;
    localparam logic [PCT_W-1:0]  BASE_FAIR = 7'd50;
    localparam logic [PCT_W-1:0]  BASE_LOW  = 7'd25;
    localparam logic [PCT_W-1:0]  BASE_CRIT = 7'd5;
    localparam logic [PCT_W-1:0]  BASE_EMPT = 7'd0;
    localparam logic [SPAN_W-1:0] SPAN_WIDE = 5'd25;
    localparam logic [SPAN_W-1:0] SPAN_CRIT = 5'd20;
    localparam logic [SPAN_W-1:0] SPAN_EMPT = 5'd5;

    // register indexes, byte address = 4 * index
    localparam logic [2:0] REG_GAIN     = 3'd0;
    localparam logic [2:0] REG_FULL     = 3'd1;
    localparam logic [2:0] REG_GOOD     = 3'd2;
    localparam logic [2:0] REG_NOMINAL  = 3'd3;
    localparam logic [2:0] REG_LOW      = 3'd4;
    localparam logic [2:0] REG_CRITICAL = 3'd5;
    localparam logic [2:0] REG_EMPTY    = 3'd6;

    typedef enum logic [2:0] {
        ST_FULL     = 3'd0,
        ST_GOOD     = 3'd1,
        ST_FAIR     = 3'd2,
        ST_LOW      = 3'd3,
        ST_CRITICAL = 3'd4,
        ST_EMPTY    = 3'd5
    } t_status;

    typedef enum logic [3:0] {
        S_IDLE,
        S_MUL,
        S_SCALE,
        S_RECIP,
        S_RAW,
        S_SMUL,
        S_SMOOTH,
        S_CLASS,
        S_BMUL,
        S_BDIV,
        S_OUT
    } t_back_state;

    typedef struct packed {
        logic [GAIN_W-1:0] gain_q4_12;
        logic [MV_W-1:0]   full_mv;
        logic [MV_W-1:0]   good_mv;
        logic [MV_W-1:0]   nominal_mv;
        logic [MV_W-1:0]   low_mv;
        logic [MV_W-1:0]   critical_mv;
        logic [MV_W-1:0]   empty_mv;
    } t_cfg;

    typedef struct packed {
        logic [MV_W-1:0]  voltage_mv;
        logic [PCT_W-1:0] percent;
        t_status          status;
        logic [SEG_W-1:0] segments;
        logic             low_flag;
        logic             critical_flag;
    } t_result;

endpackage

FILE: rtl/bgs_front.sv
// Front end: sums one burst of samples and hands the closed sum on.
// Depends on bgs_pkg.
`timescale 1ns / 1ps

module bgs_front
    import bgs_pkg::*;
#(
    parameter int SAMPLES = SAMPLES_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_accept,
    input  logic [SAMPLE_W-1:0] i_sample_mv,
    output logic                o_q_push,
    output logic [SUM_W-1:0]    o_q_data
);

    localparam logic [CNT_W-1:0] LAST = CNT_W'(SAMPLES - 1);

    logic [SUM_W-1:0] r_sum, n_sum;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic [SUM_W-1:0] sum_next;

    assign sum_next = r_sum + SUM_W'(i_sample_mv);

    always_comb begin
        n_sum    = r_sum;
        n_cnt    = r_cnt;
        o_q_push = 1'b0;
        o_q_data = sum_next;
        if (i_accept) begin
            if (r_cnt == LAST) begin
                // burst closes: hand the sum on and start over
                o_q_push = 1'b1;
                n_sum    = '0;
                n_cnt    = '0;
            end else begin
                n_sum = sum_next;
                n_cnt = r_cnt + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum <= '0;
            r_cnt <= '0;
        end else begin
            r_sum <= n_sum;
            r_cnt <= n_cnt;
        end
    end

endmodule

FILE: rtl/bgs_fifo.sv
// Short queue of closed burst sums between front and back end.
// Depends on bgs_pkg.
`timescale 1ns / 1ps

module bgs_fifo
    import bgs_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [SUM_W-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic [SUM_W-1:0] o_data,
    output logic             o_empty
);

    logic [SUM_W-1:0]  r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wptr, r_rptr;
    logic [QPTR_W:0]   r_cnt;
    logic              do_push, do_pop;

    assign o_full  = (r_cnt == (QPTR_W + 1)'(QUEUE_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_data  = r_mem[r_rptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            if (do_push) begin
                r_wptr <= r_wptr + QPTR_W'(1);
            end
            if (do_pop) begin
                r_rptr <= r_rptr + QPTR_W'(1);
            end
            r_cnt <= r_cnt + (QPTR_W + 1)'(do_push) - (QPTR_W + 1)'(do_pop);
        end
    end

endmodule

FILE: rtl/bgs_div.sv
// Restoring divider, two quotient bits per cycle.
// Depends on bgs_pkg.
`timescale 1ns / 1ps

module bgs_div
    import bgs_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [DIV_W-1:0]  i_dividend,
    input  logic [DVSR_W-1:0] i_divisor,
    output logic              o_done,
    output logic [DIV_W-1:0]  o_quotient
);

    logic [DVSR_W-1:0]    r_rem, n_rem;
    logic [DIV_W-1:0]     r_quo, n_quo;
    logic [DVSR_W-1:0]    r_dvsr;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic                 r_busy, r_done;

    // two dependent shift-subtract steps
    always_comb begin
        logic [DVSR_W:0] t;
        n_rem = r_rem;
        n_quo = r_quo;
        for (int k = 0; k < 2; k++) begin
            t     = {n_rem, n_quo[DIV_W-1]};
            n_quo = {n_quo[DIV_W-2:0], 1'b0};
            if (t >= {1'b0, r_dvsr}) begin
                t        = t - {1'b0, r_dvsr};
                n_quo[0] = 1'b1;
            end
            n_rem = t[DVSR_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem  <= '0;
            r_quo  <= i_dividend;
            r_dvsr <= i_divisor;
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_quo <= n_quo;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= DIV_CNT_W'(DIV_STEPS);
            end else if (r_busy) begin
                r_cnt <= r_cnt - DIV_CNT_W'(1);
                if (r_cnt == DIV_CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

FILE: rtl/bgs_back.sv
// Back end: scales, smooths and grades one burst sum, holds the result.
// Depends on bgs_pkg and bgs_div.
`timescale 1ns / 1ps

module bgs_back
    import bgs_pkg::*;
#(
    parameter int SAMPLES = SAMPLES_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_cfg             i_cfg,
    input  logic             i_q_empty,
    input  logic [SUM_W-1:0] i_q_data,
    output logic             o_q_pop,
    input  logic             i_pop,
    output logic             o_valid,
    output t_result          o_result
);

    // half of SAMPLES * 4096, for round-half-up
    localparam logic [PROD_W-1:0] HALF = PROD_W'(SAMPLES * 2048);
    // ceil(2^24 / SAMPLES): exact floor divide for any 20-bit dividend
    localparam logic [RECIP_W-1:0] RECIP_S =
        RECIP_W'((2 ** RECIP_SHIFT + SAMPLES - 1) / SAMPLES);

    t_back_state        r_state, n_state;
    logic [SUM_W-1:0]   r_sum, n_sum;
    logic [PROD_W-1:0]  r_prod, n_prod;
    logic [MV_W-1:0]    r_smooth, n_smooth;
    logic [MV_W-1:0]    r_off, n_off;
    logic [MV_W-1:0]    r_width, n_width;
    logic [PCT_W-1:0]   r_base, n_base;
    logic [SPAN_W-1:0]  r_span, n_span;
    t_status            r_status, n_status;
    logic               r_low, n_low;
    logic               r_crit, n_crit;
    logic [PCT_W-1:0]   r_pct, n_pct;
    t_result            r_out, n_out;
    logic               r_out_valid, n_out_valid;

    logic               div_start, div_done;
    logic [DIV_W-1:0]   div_dividend, div_quo;
    logic [DVSR_W-1:0]  div_divisor;

    t_status            c_status;
    logic [MV_W-1:0]    c_lo, c_hi;
    logic [PCT_W-1:0]   c_base;
    logic [SPAN_W-1:0]  c_span;

    logic [PROD_W-1:0]  scaled;
    logic [MV_W-1:0]    raw;
    logic [MV_W:0]      smooth_q;
    logic [PCT_W:0]     pct_sum;
    logic [SEG_W-1:0]   seg;

    bgs_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dividend),
        .i_divisor  (div_divisor),
        .o_done     (div_done),
        .o_quotient (div_quo)
    );

    // band selection, top threshold first
    always_comb begin
        c_status = ST_EMPTY;
        c_lo     = i_cfg.empty_mv;
        c_hi     = i_cfg.critical_mv;
        c_base   = BASE_EMPT;
        c_span   = SPAN_EMPT;
        priority if (r_smooth >= i_cfg.full_mv) begin
            c_status = ST_FULL;
        end else if (r_smooth >= i_cfg.good_mv) begin
            c_status = ST_GOOD;
            c_lo     = i_cfg.good_mv;
            c_hi     = i_cfg.full_mv;
            c_base   = BASE_GOOD;
            c_span   = SPAN_WIDE;
        end else if (r_smooth >= i_cfg.nominal_mv) begin
            c_status = ST_FAIR;
            c_lo     = i_cfg.nominal_mv;
            c_hi     = i_cfg.good_mv;
            c_base   = BASE_FAIR;
            c_span   = SPAN_WIDE;
        end else if (r_smooth >= i_cfg.low_mv) begin
            c_status = ST_LOW;
            c_lo     = i_cfg.low_mv;
            c_hi     = i_cfg.nominal_mv;
            c_base   = BASE_LOW;
            c_span   = SPAN_WIDE;
        end else if (r_smooth >= i_cfg.critical_mv) begin
            c_status = ST_CRITICAL;
            c_lo     = i_cfg.critical_mv;
            c_hi     = i_cfg.low_mv;
            c_base   = BASE_CRIT;
            c_span   = SPAN_CRIT;
        end else begin
            c_status = ST_EMPTY;
        end
    end

    assign scaled   = r_prod + HALF;
    assign raw      = (r_prod[RECIP_SHIFT +: DIV_W] > DIV_W'(MV_MAX)) ? MV_MAX
                                                                     : r_prod[RECIP_SHIFT +: MV_W];
    assign smooth_q = r_prod[RECIP5_SHIFT +: MV_W + 1];
    assign pct_sum  = {1'b0, r_base} + (PCT_W + 1)'(div_quo[PCT_W-1:0]);
    assign seg      = (r_pct >= BASE_GOOD) ? SEG_W'(3) :
                      (r_pct >= BASE_FAIR) ? SEG_W'(2) :
                      (r_pct >= BASE_LOW)  ? SEG_W'(1) : SEG_W'(0);

    always_comb begin
        n_state      = r_state;
        n_sum        = r_sum;
        n_prod       = r_prod;
        n_smooth     = r_smooth;
        n_off        = r_off;
        n_width      = r_width;
        n_base       = r_base;
        n_span       = r_span;
        n_status     = r_status;
        n_low        = r_low;
        n_crit       = r_crit;
        n_pct        = r_pct;
        n_out        = r_out;
        n_out_valid  = r_out_valid && !i_pop;
        o_q_pop      = 1'b0;
        div_start    = 1'b0;
        div_dividend = '0;
        div_divisor  = '0;
        unique case (r_state)
            S_IDLE: begin
                if (!i_q_empty) begin
                    o_q_pop = 1'b1;
                    n_sum   = i_q_data;
                    n_state = S_MUL;
                end
            end
            S_MUL: begin
                n_prod  = PROD_W'(r_sum) * PROD_W'(i_cfg.gain_q4_12);
                n_state = S_SCALE;
            end
            S_SCALE: begin
                // sum * gain + half, then / 4096 and / SAMPLES
                n_prod  = scaled;
                n_state = S_RECIP;
            end
            S_RECIP: begin
                // divide by SAMPLES through the reciprocal
                n_prod  = PROD_W'(r_prod[SCALE_SHIFT +: DIV_W]) * PROD_W'(RECIP_S);
                n_state = S_RAW;
            end
            S_RAW: begin
                if (r_smooth == '0) begin
                    n_smooth = raw;
                    n_state  = S_CLASS;
                end else begin
                    n_prod  = PROD_W'({r_smooth, 2'b00}) + PROD_W'(raw) + PROD_W'(2);
                    n_state = S_SMUL;
                end
            end
            S_SMUL: begin
                // divide by 5 through the reciprocal, exact below 2^18
                n_prod  = PROD_W'(r_prod[SMOOTH_X_W-1:0]) * PROD_W'(RECIP5);
                n_state = S_SMOOTH;
            end
            S_SMOOTH: begin
                n_smooth = (smooth_q > (MV_W + 1)'(MV_MAX)) ? MV_MAX : smooth_q[MV_W-1:0];
                n_state  = S_CLASS;
            end
            S_CLASS: begin
                n_status = c_status;
                n_low    = (r_smooth < i_cfg.low_mv);
                n_crit   = (r_smooth < i_cfg.critical_mv);
                n_off    = r_smooth - c_lo;
                n_width  = c_hi - c_lo;
                n_base   = c_base;
                n_span   = c_span;
                if (c_status == ST_FULL) begin
                    n_pct   = PCT_MAX;
                    n_state = S_OUT;
                end else if (c_status == ST_EMPTY && r_smooth < i_cfg.empty_mv) begin
                    n_pct   = '0;
                    n_state = S_OUT;
                end else begin
                    n_state = S_BMUL;
                end
            end
            S_BMUL: begin
                div_start    = 1'b1;
                div_dividend = DIV_W'(r_off) * DIV_W'(r_span);
                div_divisor  = r_width;
                n_state      = S_BDIV;
            end
            S_BDIV: begin
                if (div_done) begin
                    n_pct   = (pct_sum > (PCT_W + 1)'(PCT_MAX)) ? PCT_MAX
                                                              : pct_sum[PCT_W-1:0];
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (!r_out_valid || i_pop) begin
                    n_out.voltage_mv    = r_smooth;
                    n_out.percent       = r_pct;
                    n_out.status        = r_status;
                    n_out.segments      = seg;
                    n_out.low_flag      = r_low;
                    n_out.critical_flag = r_crit;
                    n_out_valid         = 1'b1;
                    n_state             = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_smooth    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_smooth    <= n_smooth;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_sum    <= n_sum;
        r_prod   <= n_prod;
        r_off    <= n_off;
        r_width  <= n_width;
        r_base   <= n_base;
        r_span   <= n_span;
        r_status <= n_status;
        r_low    <= n_low;
        r_crit   <= n_crit;
        r_pct    <= n_pct;
        r_out    <= n_out;
    end

    assign o_valid  = r_out_valid;
    assign o_result = r_out;

endmodule

FILE: rtl/battery_gauge_smoother_core.sv
// Top level of the battery gauge smoother: register port, front, queue, back.
// Depends on bgs_pkg, bgs_front, bgs_fifo and bgs_back.
`timescale 1ns / 1ps

// Voltage fuel gauge for a Li-ion cell. Each beat on the input side carries
// one ADC sample in millivolts; every SAMPLES beats close a burst, and each
// burst yields exactly one beat on the result side: the smoothed voltage
// (mean times the Q4.12 gain, rounded, then an 80/20 running average whose
// first nonzero reading is loaded as is), the piecewise-linear percentage,
// the band status, display segments and low/critical flags. Samples are
// taken one per cycle while full is low; a burst sum goes into a two-entry
// queue and full rises only when that queue holds two sums. For a reading
// that falls inside a band, the back end waits on the radix-4 divider for
// the band fraction; its other steps are one multiply, add or compare each
// (the divide by SAMPLES is a reciprocal multiply). A reading at or above
// full_mv, or below empty_mv in the bottom band, skips the divider; the
// first nonzero reading skips the smoothing multiply and divide. An
// unpopped result holds the back end in its last step, so with pop kept
// high a new burst is summed while the back end grades the previous one.
// Thresholds and gain sit in seven APB registers at byte
// addresses 0 to 24; write them only while no burst is in flight.

module battery_gauge_smoother_core
    import bgs_pkg::*;
#(
    parameter int SAMPLES = SAMPLES_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // APB register port
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    // sample side
    input  logic                  push,
    output logic                  full,
    input  logic [SAMPLE_W-1:0]   i_sample_mv,
    // result side
    output logic                  empty,
    input  logic                  pop,
    output logic [MV_W-1:0]       o_voltage_mv,
    output logic [PCT_W-1:0]      o_percent,
    output logic [2:0]            o_status,
    output logic [SEG_W-1:0]      o_segments,
    output logic                  o_low_flag,
    output logic                  o_critical_flag
);

    t_cfg             r_cfg;
    logic [2:0]       reg_idx;
    logic             cfg_wr;
    logic             in_accept;
    logic             q_push, q_pop, q_empty, q_full;
    logic [SUM_W-1:0] q_wdata, q_rdata;
    logic             res_valid;
    t_result          res;

    // ---------------- register port ----------------
    assign pready  = 1'b1;
    assign reg_idx = paddr[4:2];
    assign cfg_wr  = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.gain_q4_12  <= 16'd8192;
            r_cfg.full_mv     <= 14'd4200;
            r_cfg.good_mv     <= 14'd4000;
            r_cfg.nominal_mv  <= 14'd3800;
            r_cfg.low_mv      <= 14'd3600;
            r_cfg.critical_mv <= 14'd3400;
            r_cfg.empty_mv    <= 14'd3200;
        end else if (cfg_wr) begin
            unique case (reg_idx)
                REG_GAIN:     r_cfg.gain_q4_12  <= pwdata[GAIN_W-1:0];
                REG_FULL:     r_cfg.full_mv     <= pwdata[MV_W-1:0];
                REG_GOOD:     r_cfg.good_mv     <= pwdata[MV_W-1:0];
                REG_NOMINAL:  r_cfg.nominal_mv  <= pwdata[MV_W-1:0];
                REG_LOW:      r_cfg.low_mv      <= pwdata[MV_W-1:0];
                REG_CRITICAL: r_cfg.critical_mv <= pwdata[MV_W-1:0];
                REG_EMPTY:    r_cfg.empty_mv    <= pwdata[MV_W-1:0];
                default: begin
                    // unmapped address: write dropped
                end
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_GAIN:     prdata = APB_DATA_W'(r_cfg.gain_q4_12);
            REG_FULL:     prdata = APB_DATA_W'(r_cfg.full_mv);
            REG_GOOD:     prdata = APB_DATA_W'(r_cfg.good_mv);
            REG_NOMINAL:  prdata = APB_DATA_W'(r_cfg.nominal_mv);
            REG_LOW:      prdata = APB_DATA_W'(r_cfg.low_mv);
            REG_CRITICAL: prdata = APB_DATA_W'(r_cfg.critical_mv);
            REG_EMPTY:    prdata = APB_DATA_W'(r_cfg.empty_mv);
            default:      prdata = '0;
        endcase
    end

    // ---------------- front: burst accumulation ----------------
    // A sample beat is taken whenever the queue has room, so the
    // closing sample of a burst always finds a free entry.
    assign full      = q_full;
    assign in_accept = push && !q_full;

    bgs_front #(
        .SAMPLES (SAMPLES)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (in_accept),
        .i_sample_mv (i_sample_mv),
        .o_q_push    (q_push),
        .o_q_data    (q_wdata)
    );

    // ---------------- queue of closed burst sums ----------------
    bgs_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_wdata),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_data  (q_rdata),
        .o_empty (q_empty)
    );

    // ---------------- back: scale, smooth, grade ----------------
    // The back end owns the result register; it keeps working on the
    // next burst while a finished result waits to be popped.
    bgs_back #(
        .SAMPLES (SAMPLES)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (r_cfg),
        .i_q_empty (q_empty),
        .i_q_data  (q_rdata),
        .o_q_pop   (q_pop),
        .i_pop     (pop),
        .o_valid   (res_valid),
        .o_result  (res)
    );

    assign empty           = !res_valid;
    assign o_voltage_mv    = res.voltage_mv;
    assign o_percent       = res.percent;
    assign o_status        = res.status;
    assign o_segments      = res.segments;
    assign o_low_flag      = res.low_flag;
    assign o_critical_flag = res.critical_flag;

endmodule

FILE: rtl/bgs_checker.sv
// Port-level checks of the battery gauge smoother, bound to the top level.
// Depends on bgs_pkg and battery_gauge_smoother_core_defines.svh.
`timescale 1ns / 1ps
`include "battery_gauge_smoother_core_defines.svh"

module bgs_checker
    import bgs_pkg::*;
(
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             empty,
    input logic             pop,
    input logic [MV_W-1:0]  o_voltage_mv,
    input logic [PCT_W-1:0] o_percent,
    input logic [2:0]       o_status,
    input logic [SEG_W-1:0] o_segments
);

    // result fields stay in their ranges
    `BGS_ASSERT_IMPLY(a_range, i_clk, i_rst_n, !empty, (o_percent <= PCT_MAX) && (o_status <= ST_EMPTY))

    // segment count follows the percentage
    `BGS_ASSERT_IMPLY(a_segments, i_clk, i_rst_n, !empty, o_segments == ((o_percent >= 7'd75) ? 2'd3 : (o_percent >= 7'd50) ? 2'd2 : (o_percent >= 7'd25) ? 2'd1 : 2'd0))

    // a full battery always reads one hundred percent
    `BGS_ASSERT_IMPLY(a_full_pct, i_clk, i_rst_n, !empty && (o_status == ST_FULL), o_percent == PCT_MAX)

    // a waiting result beat holds until it is popped
    `BGS_ASSERT_NEXT(a_hold, i_clk, i_rst_n, !empty && !pop, !empty && $stable(o_voltage_mv) && $stable(o_percent))

endmodule

bind battery_gauge_smoother_core bgs_checker u_bgs_checker (.*);

FILE: bench/bgs_reading_checker.sv
// Scoreboard for the battery gauge smoother: tracks registers, predicts readings, compares.
// Depends on bgs_pkg; instantiated beside the block by battery_gauge_smoother_core_tb.
`timescale 1ns / 1ps

module bgs_reading_checker
    import bgs_pkg::*;
#(
    parameter int SAMPLES = SAMPLES_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic                  pready,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    input  logic                  push,
    input  logic                  full,
    input  logic [SAMPLE_W-1:0]   i_sample_mv,
    input  logic                  empty,
    input  logic                  pop,
    input  logic [MV_W-1:0]       o_voltage_mv,
    input  logic [PCT_W-1:0]      o_percent,
    input  logic [2:0]            o_status,
    input  logic [SEG_W-1:0]      o_segments,
    input  logic                  o_low_flag,
    input  logic                  o_critical_flag,
    output int                    o_fail_count,
    output int                    o_readings_due
);

    localparam t_cfg CFG_RESET = '{
        gain_q4_12:  16'd8192,
        full_mv:     14'd4200,
        good_mv:     14'd4000,
        nominal_mv:  14'd3800,
        low_mv:      14'd3600,
        critical_mv: 14'd3400,
        empty_mv:    14'd3200
    };

    // percent thresholds for the display segments
    localparam int SEG3_PCT = 75;
    localparam int SEG2_PCT = 50;
    localparam int SEG1_PCT = 25;

    t_cfg             regs;
    logic [SUM_W-1:0] burst_sum;
    logic [CNT_W-1:0] burst_len;
    logic [MV_W-1:0]  avg_mv;
    t_result          readings[$];
    t_result          oldest;
    int               fails;

    // Close one burst: scale, smooth (updates avg_mv), classify.
    function automatic t_result settle_reading(input logic [SUM_W-1:0] sum);
        logic [63:0]       raw;
        logic [63:0]       mixed;
        logic [MV_W-1:0]   v;
        logic [MV_W-1:0]   lo;
        logic [MV_W-1:0]   hi;
        logic [PCT_W-1:0]  base;
        logic [SPAN_W-1:0] span;
        logic [31:0]       pct;
        t_result           r;
        raw = (64'(sum) * 64'(regs.gain_q4_12) + 64'(SAMPLES * 2048)) / 64'(SAMPLES * 4096);
        if (raw > 64'(MV_MAX)) raw = 64'(MV_MAX);
        if (avg_mv == '0) mixed = raw;
        else mixed = (64'(avg_mv) * 4 + raw + 2) / 5;
        if (mixed > 64'(MV_MAX)) mixed = 64'(MV_MAX);
        avg_mv = mixed[MV_W-1:0];
        v = avg_mv;

        // below empty_mv: zero span gives 0 percent
        lo   = '0;
        hi   = 14'd1;
        base = BASE_EMPT;
        span = '0;
        if (v >= regs.full_mv) begin
            r.status = ST_FULL;
            pct = 32'(PCT_MAX);
        end else begin
            if (v >= regs.good_mv) begin
                r.status = ST_GOOD;
                lo = regs.good_mv; hi = regs.full_mv; base = BASE_GOOD; span = SPAN_WIDE;
            end else if (v >= regs.nominal_mv) begin
                r.status = ST_FAIR;
                lo = regs.nominal_mv; hi = regs.good_mv; base = BASE_FAIR; span = SPAN_WIDE;
            end else if (v >= regs.low_mv) begin
                r.status = ST_LOW;
                lo = regs.low_mv; hi = regs.nominal_mv; base = BASE_LOW; span = SPAN_WIDE;
            end else if (v >= regs.critical_mv) begin
                r.status = ST_CRITICAL;
                lo = regs.critical_mv; hi = regs.low_mv; base = BASE_CRIT; span = SPAN_CRIT;
            end else if (v >= regs.empty_mv) begin
                r.status = ST_EMPTY;
                lo = regs.empty_mv; hi = regs.critical_mv; base = BASE_EMPT; span = SPAN_EMPT;
            end else begin
                r.status = ST_EMPTY;
            end
            pct = 32'(base) + ((32'(v) - 32'(lo)) * 32'(span)) / (32'(hi) - 32'(lo));
        end
        if (pct > 32'(PCT_MAX)) pct = 32'(PCT_MAX);

        r.voltage_mv    = v;
        r.percent       = pct[PCT_W-1:0];
        r.segments      = (pct >= SEG3_PCT) ? 2'd3 : (pct >= SEG2_PCT) ? 2'd2 :
                          (pct >= SEG1_PCT) ? 2'd1 : 2'd0;
        r.low_flag      = (v < regs.low_mv);
        r.critical_flag = (v < regs.critical_mv);
        return r;
    endfunction

    task automatic check_field(input string what, input int want, input int got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
            fails++;
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            regs      = CFG_RESET;
            burst_sum = '0;
            burst_len = '0;
            avg_mv    = '0;
            fails     = 0;
            readings.delete();
            o_fail_count   <= 0;
            o_readings_due <= 0;
        end else begin
            if (psel && penable && pwrite && pready) begin
                case (paddr[APB_ADDR_W-1:2])
                    REG_GAIN:     regs.gain_q4_12  = pwdata[GAIN_W-1:0];
                    REG_FULL:     regs.full_mv     = pwdata[MV_W-1:0];
                    REG_GOOD:     regs.good_mv     = pwdata[MV_W-1:0];
                    REG_NOMINAL:  regs.nominal_mv  = pwdata[MV_W-1:0];
                    REG_LOW:      regs.low_mv      = pwdata[MV_W-1:0];
                    REG_CRITICAL: regs.critical_mv = pwdata[MV_W-1:0];
                    REG_EMPTY:    regs.empty_mv    = pwdata[MV_W-1:0];
                    default: ;
                endcase
            end

            if (push && !full) begin
                burst_sum = burst_sum + SUM_W'(i_sample_mv);
                if (32'(burst_len) + 1 < SAMPLES) begin
                    burst_len = burst_len + 1'b1;
                end else begin
                    readings.push_back(settle_reading(burst_sum));
                    burst_sum = '0;
                    burst_len = '0;
                end
            end

            if (pop && !empty) begin
                if (readings.size() == 0) begin
                    $display("%0t: result beat with no reading due, expected none, actual %0d mV",
                             $time, o_voltage_mv);
                    fails++;
                end else begin
                    oldest = readings.pop_front();
                    check_field("voltage_mv", oldest.voltage_mv, o_voltage_mv);
                    check_field("percent", oldest.percent, o_percent);
                    check_field("status", int'(oldest.status), o_status);
                    check_field("segments", oldest.segments, o_segments);
                    check_field("low_flag", oldest.low_flag, o_low_flag);
                    check_field("critical_flag", oldest.critical_flag, o_critical_flag);
                end
            end

            o_fail_count   <= fails;
            o_readings_due <= readings.size();
        end
    end

endmodule

FILE: bench/battery_gauge_smoother_core_tb.sv
// Testbench top for battery_gauge_smoother_core: clock, reset, sample and register stimulus.
// Depends on bgs_pkg, the block and bgs_reading_checker, which does all the comparing.
`timescale 1ns / 1ps

module battery_gauge_smoother_core_tb;
    import bgs_pkg::*;

    localparam int SAMPLES     = SAMPLES_DEF;
    localparam int CYCLE_LIMIT = 400000;   // far above the length of the slowest correct run
    localparam int SETTLE_GAP  = 64;       // wait after the last reading before registers are touched
    localparam int PHASE_LEN   = 17;       // bursts per register setting

    // address slot past the last register; writes there must be dropped
    localparam logic [2:0] REG_SPARE = 3'd7;

    // upper bits that the registers ignore, set at random on writes
    localparam logic [31:0] GAIN_JUNK = 32'hFFFF_0000;
    localparam logic [31:0] MV_JUNK   = 32'hFFFF_C000;

    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  psel        = 1'b0;
    logic                  penable     = 1'b0;
    logic                  pwrite      = 1'b0;
    logic [APB_ADDR_W-1:0] paddr       = '0;
    logic [APB_DATA_W-1:0] pwdata      = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;
    logic                  push        = 1'b0;
    logic                  full;
    logic [SAMPLE_W-1:0]   i_sample_mv = '0;
    logic                  empty;
    logic                  pop         = 1'b0;
    logic [MV_W-1:0]       o_voltage_mv;
    logic [PCT_W-1:0]      o_percent;
    logic [2:0]            o_status;
    logic [SEG_W-1:0]      o_segments;
    logic                  o_low_flag;
    logic                  o_critical_flag;

    int fail_count;
    int readings_due;
    int cycles    = 0;
    int pop_hold  = 0;
    bit gaps_on   = 1'b1;

    // What the registers hold now, masked to their widths; only used to aim
    // the sample stream at the band edges, never for checking.
    int reg_shadow [7] = '{8192, 4200, 4000, 3800, 3600, 3400, 3200};
    int aim_mv = 3600;

    battery_gauge_smoother_core #(
        .SAMPLES(SAMPLES)
    ) uut (.*);

    bgs_reading_checker #(
        .SAMPLES(SAMPLES)
    ) checker_i (
        .*,
        .o_fail_count  (fail_count),
        .o_readings_due(readings_due)
    );

    // 20 ns clock
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Watchdog: a hung handshake or a lost result ends the run here.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("FAIL battery_gauge_smoother_core");
            $finish;
        end
    end

    // Result side: pop mostly high, with random stall bursts while gaps are
    // on. Independent of empty so that stalls land on every phase.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pop <= 1'b0;
        end else if (pop_hold > 0) begin
            pop_hold <= pop_hold - 1;
            pop      <= 1'b0;
        end else if (gaps_on && $urandom_range(0, 5) == 0) begin
            pop_hold <= int'($urandom_range(0, 5));
            pop      <= 1'b0;
        end else begin
            pop <= 1'b1;
        end
    end

    // One sample beat. push stays high across back-to-back beats; a gap
    // first drops it low.
    task automatic send_sample(input logic [SAMPLE_W-1:0] mv);
        if (gaps_on && $urandom_range(0, 4) == 0) begin
            push <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
        push        <= 1'b1;
        i_sample_mv <= mv;
        do @(posedge i_clk); while (full);
    endtask

    task automatic send_flat(input logic [SAMPLE_W-1:0] mv);
        repeat (SAMPLES) send_sample(mv);
    endtask

    // One burst of SAMPLES beats. Most bursts sit close to a sample level
    // that lands the scaled mean near a threshold, so the smoothed voltage
    // walks across band edges; the rest are uniform noise or flat extremes.
    task automatic send_burst();
        int mode;
        int centre;
        int mv;
        mode = int'($urandom_range(0, 19));
        if ($urandom_range(0, 3) == 0)
            aim_mv = reg_shadow[$urandom_range(1, 6)] + int'($urandom_range(0, 60)) - 30;
        if (reg_shadow[REG_GAIN] == 0) centre = int'($urandom_range(0, 4095));
        else centre = aim_mv * 4096 / reg_shadow[REG_GAIN];

        if (mode == 17) begin
            send_flat('0);
        end else if (mode == 18) begin
            send_flat('1);
        end else begin
            repeat (SAMPLES) begin
                if (mode < 12) mv = centre + int'($urandom_range(0, 16)) - 8;
                else if (mode < 17) mv = int'($urandom_range(0, 4095));
                else mv = centre + int'($urandom_range(0, 400)) - 200;
                if (mv < 0) mv = 0;
                if (mv > 4095) mv = 4095;
                send_sample(SAMPLE_W'(mv));
            end
        end
    endtask

    // Bursts, then hold the sender until every reading is out and the back
    // end has had time to go quiet. Registers are only touched after this.
    task automatic run_phase(input int bursts);
        repeat (bursts) send_burst();
        push <= 1'b0;
        do @(posedge i_clk); while (readings_due != 0);
        repeat (SETTLE_GAP) @(posedge i_clk);
    endtask

    // APB write: setup then access. psel stays high between writes of one
    // batch; load_settings drops it at the end.
    task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        penable <= 1'b0;
        if (idx == REG_GAIN) reg_shadow[idx] = int'(value[GAIN_W-1:0]);
        else if (idx != REG_SPARE) reg_shadow[idx] = int'(value[MV_W-1:0]);
    endtask

    task automatic load_settings(input logic [31:0] gain, input logic [31:0] full_v,
                                 input logic [31:0] good_v, input logic [31:0] nominal_v,
                                 input logic [31:0] low_v, input logic [31:0] critical_v,
                                 input logic [31:0] empty_v);
        write_reg(REG_GAIN,     gain       | ($urandom & GAIN_JUNK));
        write_reg(REG_FULL,     full_v     | ($urandom & MV_JUNK));
        write_reg(REG_GOOD,     good_v     | ($urandom & MV_JUNK));
        write_reg(REG_NOMINAL,  nominal_v  | ($urandom & MV_JUNK));
        write_reg(REG_LOW,      low_v      | ($urandom & MV_JUNK));
        write_reg(REG_CRITICAL, critical_v | ($urandom & MV_JUNK));
        write_reg(REG_EMPTY,    empty_v    | ($urandom & MV_JUNK));
        write_reg(REG_SPARE,    $urandom);
        psel   <= 1'b0;
        pwrite <= 1'b0;
    endtask

    // Ordered thresholds, empty_mv upward, rungs 1..step_max mV apart until clamped at 16383 mV.
    task automatic load_ladder(input logic [31:0] gain, input int step_max);
        int rung [6];
        rung[0] = int'($urandom_range(0, 12000));
        for (int k = 1; k < 6; k++) begin
            rung[k] = rung[k-1] + int'($urandom_range(1, step_max));
            if (rung[k] > 16383) rung[k] = 16383;
        end
        load_settings(gain, rung[5], rung[4], rung[3], rung[2], rung[1], rung[0]);
    endtask

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset settings. First burst is all zeros: raw reading of 0 with no
        // reading held, so the average stays at 0. The full-scale burst after
        // it is then loaded directly instead of being blended.
        send_flat('0);
        send_flat('1);
        run_phase(PHASE_LEN - 2);

        // Full gain: a full-scale mean saturates at 16383 mV.
        load_ladder(32'h0000_FFFF, 3000);
        run_phase(PHASE_LEN);

        // Zero gain, all thresholds 0: every reading counts as full.
        load_settings('0, '0, '0, '0, '0, '0, '0);
        run_phase(PHASE_LEN);

        // All thresholds at the top: everything below reads empty.
        load_settings($urandom_range(0, 65535), 16383, 16383, 16383, 16383, 16383, 16383);
        run_phase(PHASE_LEN);

        // Unordered thresholds: some bands can never be entered.
        load_settings($urandom_range(4096, 16384),
                      $urandom_range(0, 16383), $urandom_range(0, 16383),
                      $urandom_range(0, 16383), $urandom_range(0, 16383),
                      $urandom_range(0, 16383), $urandom_range(0, 16383));
        run_phase(PHASE_LEN);

        // Narrow bands a few mV wide, to exercise the band edges and the divide.
        load_ladder($urandom_range(4096, 12288), 4);
        run_phase(PHASE_LEN);

        // Back to the power-on values.
        load_settings(8192, 4200, 4000, 3800, 3600, 3400, 3200);
        run_phase(PHASE_LEN);

        // Last stretch runs with no gaps on either side.
        gaps_on <= 1'b0;
        load_ladder($urandom_range(4096, 16384), 800);
        run_phase(PHASE_LEN);

        if (fail_count == 0) begin
            $display("PASS battery_gauge_smoother_core");
        end else begin
            $display("FAIL battery_gauge_smoother_core");
        end
        $finish;
    end

endmodule
